[hw/rtl/sat_pkg.sv]
`timescale 1ns / 1ps

package sat_pkg;

    localparam int TICK_W   = 32;
    localparam int PERIOD_W = 8;
    localparam int HASH_W   = 64;

    localparam logic [1:0]  OP_ADD         = 2'd0;
    localparam logic [1:0]  OP_TICK        = 2'd1;
    localparam logic [1:0]  OP_PACKET      = 2'd2;
    localparam logic [12:0] MIN_PACKET_LEN = 13'd9;
    localparam logic [12:0] MIN_ACK_LEN    = 13'd13;
    localparam logic [7:0]  ACK_OPCODE     = 8'h02;

    typedef struct packed {
        logic [1:0]        op;
        logic [HASH_W-1:0] player_hash;
        logic [12:0]       packet_length;
        logic [7:0]        packet_opcode;
        logic [TICK_W-1:0] ack_tick;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        client_index;
        logic [TICK_W-1:0] current_tick;
        logic [TICK_W-1:0] base_tick;
        logic              has_base;
        logic              last_of_run;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_TICK,
        CMD_ACK
    } cmd_kind_t;

    // command handed from the front end to the engine
    typedef struct packed {
        cmd_kind_t         kind;
        logic [HASH_W-1:0] hash;
        logic [TICK_W-1:0] ack_tick;
    } cmd_t;

endpackage

[hw/rtl/sat_front.sv]
`timescale 1ns / 1ps

module sat_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  sat_pkg::in_item_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output sat_pkg::cmd_t     cmd_data
);
    import sat_pkg::*;

    logic is_ack;
    logic drop;

    // only acks that can change state go on; short or foreign packets die here
    assign is_ack = (s_data.op == OP_PACKET) && (s_data.packet_length >= MIN_PACKET_LEN)
                  && (s_data.packet_opcode == ACK_OPCODE)
                  && (s_data.packet_length >= MIN_ACK_LEN)
                  && (s_data.ack_tick != '0);

    always_comb begin
        cmd_data.hash     = s_data.player_hash;
        cmd_data.ack_tick = s_data.ack_tick;
        drop              = 1'b0;
        unique case (s_data.op)
            OP_ADD:  cmd_data.kind = CMD_ADD;
            OP_TICK: cmd_data.kind = CMD_TICK;
            default: begin
                cmd_data.kind = CMD_ACK;
                drop          = !is_ack;
            end
        endcase
    end

    assign cmd_valid = s_valid && !drop;
    assign s_ready   = drop || cmd_ready;

endmodule

[hw/rtl/sat_queue.sv]
`timescale 1ns / 1ps

module sat_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  sat_pkg::cmd_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sat_pkg::cmd_t out_data
);
    import sat_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] level_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (level_reg != 2'd2);
    assign out_valid = (level_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            level_reg <= level_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[hw/rtl/sat_engine.sv]
`timescale 1ns / 1ps

module sat_engine #(
    parameter int MAX_CLIENTS    = 8,
    parameter int SNAPSHOT_SLOTS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [sat_pkg::PERIOD_W-1:0]     period,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  sat_pkg::cmd_t                    cmd_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output sat_pkg::out_item_t               m_data
);
    import sat_pkg::*;

    localparam int CI_W   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_CLIENTS + 1);
    localparam int SI_W   = $clog2(SNAPSHOT_SLOTS);
    localparam int FILL_W = $clog2(SNAPSHOT_SLOTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_ACK_RD,
        ST_ACK_UPD,
        ST_DIV,
        ST_STORE,
        ST_SCAN_RD,
        ST_SCAN_UPD,
        ST_EMIT
    } state_t;

    // memories
    logic [HASH_W-1:0]      hash_mem [MAX_CLIENTS];
    logic [TICK_W-1:0]      tag_mem  [SNAPSHOT_SLOTS];
    logic [MAX_CLIENTS-1:0] ack_mem  [SNAPSHOT_SLOTS];
    logic [HASH_W-1:0]      hash_rd_reg;
    logic [TICK_W-1:0]      rd_tag_reg;
    logic [MAX_CLIENTS-1:0] rd_ack_reg;
    logic                   rd_valid_reg;

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [TICK_W-1:0]      tick_reg;
    logic [SI_W-1:0]        wp_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [CI_W-1:0]        ci_reg;
    logic [CI_W-1:0]        hit_reg;
    logic [SI_W-1:0]        si_reg;
    logic [SI_W-1:0]        k_reg;
    logic [4:0]             bit_reg;
    logic [PERIOD_W-1:0]    rem_reg;
    logic [TICK_W-1:0]      ack_tick_reg;
    logic [HASH_W-1:0]      key_reg;
    logic                   found_reg [MAX_CLIENTS];
    logic [TICK_W-1:0]      base_reg  [MAX_CLIENTS];
    logic                   m_valid_reg;
    out_item_t              m_data_reg;

    logic                   pop;
    logic                   add_we;
    logic                   slot_we;
    logic [SI_W-1:0]        slot_wa;
    logic [TICK_W-1:0]      slot_wtag;
    logic [MAX_CLIENTS-1:0] slot_wack;
    logic                   ack_match;
    logic [PERIOD_W-1:0]    p_eff;
    logic [PERIOD_W:0]      div_trial;
    logic [PERIOD_W-1:0]    div_rem;
    logic                   emit_go;
    logic                   emit_last;
    logic [SI_W-1:0]        wp_inc;
    logic [SI_W-1:0]        si_dec;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign pop       = cmd_valid && cmd_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // bit-serial remainder of the tick counter by the period
    assign p_eff     = (period == '0) ? PERIOD_W'(1) : period;
    assign div_trial = {rem_reg, tick_reg[bit_reg]};
    assign div_rem   = (div_trial >= {1'b0, p_eff}) ? PERIOD_W'(div_trial - {1'b0, p_eff})
                                                    : div_trial[PERIOD_W-1:0];

    assign wp_inc = (wp_reg == SI_W'(SNAPSHOT_SLOTS - 1)) ? '0 : wp_reg + 1'b1;
    assign si_dec = (si_reg == '0) ? SI_W'(SNAPSHOT_SLOTS - 1) : si_reg - 1'b1;

    assign ack_match = rd_valid_reg && (rd_tag_reg == ack_tick_reg);
    assign add_we    = pop && (cmd_data.kind == CMD_ADD) && (cnt_reg < CNT_W'(MAX_CLIENTS));
    assign emit_go   = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign emit_last = ((CNT_W'(ci_reg) + 1'b1) == cnt_reg);

    always_comb begin
        slot_we   = 1'b0;
        slot_wa   = si_reg;
        slot_wtag = rd_tag_reg;
        slot_wack = rd_ack_reg | (MAX_CLIENTS'(1) << hit_reg);
        if (state_reg == ST_STORE) begin
            slot_we   = 1'b1;
            slot_wa   = wp_reg;
            slot_wtag = tick_reg;
            slot_wack = '0;
        end else if (state_reg == ST_ACK_UPD) begin
            slot_we = ack_match;
        end
    end

    always_ff @(posedge aclk) begin
        if (add_we) begin
            hash_mem[cnt_reg[CI_W-1:0]] <= cmd_data.hash;
        end
        hash_rd_reg <= hash_mem[ci_reg];
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            tag_mem[slot_wa] <= slot_wtag;
            ack_mem[slot_wa] <= slot_wack;
        end
        rd_tag_reg <= tag_mem[si_reg];
        rd_ack_reg <= ack_mem[si_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            tick_reg     <= '0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            // slots never written read as empty
            rd_valid_reg <= (FILL_W'(si_reg) < fill_reg);
            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        key_reg      <= cmd_data.hash;
                        ack_tick_reg <= cmd_data.ack_tick;
                        unique case (cmd_data.kind)
                            CMD_ADD: begin
                                if (add_we) begin
                                    cnt_reg <= cnt_reg + 1'b1;
                                end
                            end
                            CMD_TICK: begin
                                tick_reg  <= tick_reg + 1'b1;
                                bit_reg   <= 5'd31;
                                rem_reg   <= '0;
                                state_reg <= ST_DIV;
                            end
                            default: begin
                                ci_reg <= '0;
                                if (cnt_reg != '0) begin
                                    state_reg <= ST_FIND_RD;
                                end
                            end
                        endcase
                    end
                end
                ST_FIND_RD: state_reg <= ST_FIND_CMP;
                ST_FIND_CMP: begin
                    if (hash_rd_reg == key_reg) begin
                        hit_reg   <= ci_reg;
                        si_reg    <= '0;
                        state_reg <= ST_ACK_RD;
                    end else if (emit_last) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        ci_reg    <= ci_reg + 1'b1;
                        state_reg <= ST_FIND_RD;
                    end
                end
                ST_ACK_RD: state_reg <= ST_ACK_UPD;
                ST_ACK_UPD: begin
                    if (si_reg == SI_W'(SNAPSHOT_SLOTS - 1)) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        si_reg    <= si_reg + 1'b1;
                        state_reg <= ST_ACK_RD;
                    end
                end
                ST_DIV: begin
                    rem_reg <= div_rem;
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == '0) begin
                        state_reg <= (div_rem == '0) ? ST_STORE : ST_IDLE;
                    end
                end
                ST_STORE: begin
                    wp_reg <= wp_inc;
                    if (fill_reg != FILL_W'(SNAPSHOT_SLOTS)) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    for (int i = 0; i < MAX_CLIENTS; i++) begin
                        found_reg[i] <= 1'b0;
                        base_reg[i]  <= '0;
                    end
                    si_reg    <= wp_reg;
                    k_reg     <= '0;
                    state_reg <= (cnt_reg == '0) ? ST_IDLE : ST_SCAN_RD;
                end
                ST_SCAN_RD: state_reg <= ST_SCAN_UPD;
                ST_SCAN_UPD: begin
                    // newest to oldest: first set bit per client wins
                    if (rd_valid_reg && (rd_tag_reg != '0)) begin
                        for (int i = 0; i < MAX_CLIENTS; i++) begin
                            if (!found_reg[i] && rd_ack_reg[i]) begin
                                found_reg[i] <= 1'b1;
                                base_reg[i]  <= rd_tag_reg;
                            end
                        end
                    end
                    if (k_reg == SI_W'(SNAPSHOT_SLOTS - 1)) begin
                        ci_reg    <= '0;
                        state_reg <= ST_EMIT;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        si_reg    <= si_dec;
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        m_data_reg.client_index   <= 3'(ci_reg);
                        m_data_reg.current_tick   <= tick_reg;
                        m_data_reg.base_tick      <= base_reg[0];
                        m_data_reg.has_base       <= found_reg[0];
                        m_data_reg.last_of_run    <= emit_last;
                        for (int i = 0; i < MAX_CLIENTS - 1; i++) begin
                            found_reg[i] <= found_reg[i+1];
                            base_reg[i]  <= base_reg[i+1];
                        end
                        if (emit_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            ci_reg <= ci_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/snapshot_ack_tracker_unit.sv]
`timescale 1ns / 1ps

// snapshot ack tracker: keeps up to MAX_CLIENTS client hashes and a ring of
// SNAPSHOT_SLOTS snapshot slots, each with a tick tag and one ack bit per client.
// op 0 adds a client (ignored when full), op 1 advances the tick and, every
// snapshot_period ticks, tags the next ring slot and sends one beat per client
// with the newest tick that client acked; op 2 with a valid ack sets the
// sender's bit in every slot whose tag matches. items are classified in the
// front end and queued (two deep) for the engine, which handles one command at
// a time. an ack searches the clients in order and then visits every ring
// slot, since the hash table and the slot ring are memories with registered
// reads; a tick runs a bit-serial remainder of the tick against the period,
// and a storing tick adds a newest-first slot scan and one result beat per
// client, each beat held back while the output side stalls. no clearing pass
// after reset: unwritten slots are masked by a fill count.
module snapshot_ack_tracker_unit #(
    parameter int MAX_CLIENTS    = 8,
    parameter int SNAPSHOT_SLOTS = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sat_pkg::in_item_t            s_data,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output sat_pkg::out_item_t           m_data,
    // snapshot_period register
    input  logic                         cfg_we,
    input  logic [sat_pkg::PERIOD_W-1:0] cfg_wdata
);
    import sat_pkg::*;

    logic [PERIOD_W-1:0] period_reg;

    // front to queue
    logic fq_valid;
    logic fq_ready;
    cmd_t fq_data;

    // queue to engine
    logic qe_valid;
    logic qe_ready;
    cmd_t qe_data;

    // snapshot_period, zero is treated as one by the engine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_W'(1);
        end else if (cfg_we) begin
            period_reg <= cfg_wdata;
        end
    end

    // classify beats, drop those that cannot change state
    sat_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd_data  (fq_data)
    );

    // decouples intake from the long engine commands
    sat_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qe_valid),
        .out_ready (qe_ready),
        .out_data  (qe_data)
    );

    // tables, ring, remainder unit and result register
    sat_engine #(
        .MAX_CLIENTS    (MAX_CLIENTS),
        .SNAPSHOT_SLOTS (SNAPSHOT_SLOTS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .period    (period_reg),
        .cmd_valid (qe_valid),
        .cmd_ready (qe_ready),
        .cmd_data  (qe_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[hw/rtl/sat_checker.sv]
`timescale 1ns / 1ps

module sat_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input sat_pkg::out_item_t m_data
);
    import sat_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // a found base always has a nonzero tag, a missing one reads as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.has_base == (m_data.base_tick != '0)))
        else $error("has_base disagrees with base_tick");

    // a base never equals the tick of the snapshot being reported, whose slot was just cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.has_base && (m_data.current_tick != '0)
            |-> (m_data.base_tick != m_data.current_tick))
        else $error("base equals a slot that was just cleared");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind snapshot_ack_tracker_unit sat_checker u_sat_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
